>>> hdl/jsu_pkg.sv
// Package for the JSON string unescaper: phase encoding, result kinds,
// error codes, and the hex-digit and UTF-8 encode helpers.
// No dependencies.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_QUOTE   = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX1    = 3'd3,
        PH_PAIR_BS = 3'd4,
        PH_PAIR_U  = 3'd5,
        PH_HEX2    = 3'd6,
        PH_FINISH  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_NO_QUOTE  = 4'd1,
        ERR_CONTROL   = 4'd2,
        ERR_SHORT_ESC = 4'd3,
        ERR_BAD_ESC   = 4'd4,
        ERR_SHORT_HEX = 4'd5,
        ERR_BAD_HEX   = 4'd6,
        ERR_SURROGATE = 4'd7,
        ERR_UNTERM    = 4'd8
    } t_err;

    localparam int MAX_DATA = 4;

    typedef struct packed {
        logic [MAX_DATA-1:0][7:0] bytes;
        logic [2:0]               count;
    } t_utf8;

    // bit 4 set when the character is not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= "0" && c <= "9") begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= "a" && c <= "f") begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= "A" && c <= "F") begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [20:0] cp);
        t_utf8 r;
        r = '0;
        if (cp <= 21'h7f) begin
            r.bytes[0] = cp[7:0];
            r.count    = 3'd1;
        end else if (cp <= 21'h7ff) begin
            r.bytes[0] = 8'hc0 | {3'b000, cp[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
            r.count    = 3'd2;
        end else if (cp <= 21'hffff) begin
            r.bytes[0] = 8'he0 | {4'b0000, cp[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
            r.count    = 3'd3;
        end else begin
            r.bytes[0] = 8'hf0 | {5'b00000, cp[20:18]};
            r.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
            r.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
            r.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
            r.count    = 3'd4;
        end
        return r;
    endfunction

endpackage

>>> hdl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: one raw byte in, up to five
// decoded UTF-8 / status transfers out. Depends on jsu_pkg.
//
// Usage:
//   Slave channel: one raw text byte per transfer in i_s_tdata, starting at
//   the opening quote; i_s_tlast marks the last byte of available text.
//   Master channel: o_m_tuser gives the result kind (data, done, error),
//   o_m_tdata the decoded byte and the error code, o_m_tlast the last
//   result caused by one input byte.
//   Latency: the results of a byte start in the cycle after its transfer.
//   Throughput: an input byte causes 0 to 5 results; the result register
//   drains one per cycle while i_m_tready is high. The next byte is taken
//   in the same cycle the previous byte's last result leaves, so plain
//   characters stream at one per cycle while i_m_tready stays high.
//   Bytes that cause no result (the opening quote, a backslash, hex digits
//   that do not finish a code point) leave o_s_tready high for the next byte.
//   Reset: the decoder waits for an opening quote with no result pending.
//   After a done or error result, further bytes are taken and dropped until
//   reset. A stall on i_m_tready holds the current result and keeps
//   o_s_tready low until the last result of the run leaves.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  logic        i_s_tlast,   // end_of_text
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast    // last_of_run
);

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_hcnt, n_hcnt;
    logic [15:0]              r_acc, n_acc;
    logic [9:0]               r_hs, n_hs;

    logic [MAX_DATA-1:0][7:0] r_bytes, n_bytes;
    logic [2:0]               r_nbytes, n_nbytes;
    logic                     n_term;
    t_kind                    r_tkind, n_tkind;
    t_err                     r_terr, n_terr;
    logic [2:0]               r_total;
    logic [2:0]               r_idx;

    logic        accept;
    logic        out_xfer;
    logic [7:0]  c;
    logic        last;
    logic [4:0]  hv;
    logic [15:0] acc_next;
    t_utf8       enc;
    logic [20:0] cp;
    logic        emit;
    logic        raw;

    assign c    = i_s_tdata;
    assign last = i_s_tlast;
    assign hv   = hex_val(c);
    assign acc_next = {r_acc[11:0], hv[3:0]};

    assign o_m_tvalid = (r_idx != r_total);
    assign o_m_tlast  = (r_idx + 3'd1 == r_total);
    assign out_xfer   = o_m_tvalid && i_m_tready;
    assign o_s_tready = !o_m_tvalid || (i_m_tready && o_m_tlast);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_idx < r_nbytes) begin
            o_m_tuser = KIND_DATA;
            o_m_tdata = {4'h0, ERR_NONE, r_bytes[r_idx[1:0]]};
        end else begin
            o_m_tuser = r_tkind;
            o_m_tdata = {4'h0, r_terr, 8'h00};
        end
    end

    // per-byte decode
    always_comb begin
        n_phase = r_phase;
        n_hcnt  = r_hcnt;
        n_acc   = r_acc;
        n_hs    = r_hs;
        n_term  = 1'b0;
        n_tkind = KIND_ERROR;
        n_terr  = ERR_NONE;
        cp      = '0;
        emit    = 1'b0;
        raw     = 1'b0;
        unique case (r_phase)
            PH_QUOTE: begin
                if (c != "\"") begin
                    n_term = 1'b1;
                    n_terr = ERR_NO_QUOTE;
                end else if (last) begin
                    n_term = 1'b1;
                    n_terr = ERR_UNTERM;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (c == "\"") begin
                    n_term  = 1'b1;
                    n_tkind = KIND_DONE;
                end else if (c < 8'h20) begin
                    n_term = 1'b1;
                    n_terr = ERR_CONTROL;
                end else if (c == "\\") begin
                    if (last) begin
                        n_term = 1'b1;
                        n_terr = ERR_SHORT_ESC;
                    end else begin
                        n_phase = PH_ESC;
                    end
                end else begin
                    // raw text bytes, 0x80 and up included, pass unchanged
                    raw = 1'b1;
                    if (last) begin
                        n_term = 1'b1;
                        n_terr = ERR_UNTERM;
                    end
                end
            end
            PH_ESC: begin
                emit = 1'b1;
                unique case (c)
                    "\"":    cp = 21'h22;
                    "\\":    cp = 21'h5c;
                    "/":     cp = 21'h2f;
                    "b":     cp = 21'h08;
                    "f":     cp = 21'h0c;
                    "n":     cp = 21'h0a;
                    "r":     cp = 21'h0d;
                    "t":     cp = 21'h09;
                    default: emit = 1'b0;
                endcase
                if (emit) begin
                    n_phase = PH_BODY;
                    if (last) begin
                        n_term = 1'b1;
                        n_terr = ERR_UNTERM;
                    end
                end else if (c == "u") begin
                    if (last) begin
                        n_term = 1'b1;
                        n_terr = ERR_SHORT_HEX;
                    end else begin
                        n_phase = PH_HEX1;
                        n_hcnt  = 2'd0;
                        n_acc   = '0;
                    end
                end else begin
                    n_term = 1'b1;
                    n_terr = ERR_BAD_ESC;
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (hv[4]) begin
                    n_term = 1'b1;
                    n_terr = ERR_BAD_HEX;
                end else if (r_hcnt != 2'd3) begin
                    n_acc  = acc_next;
                    n_hcnt = r_hcnt + 2'd1;
                    if (last) begin
                        n_term = 1'b1;
                        n_terr = ERR_SHORT_HEX;
                    end
                end else begin
                    n_acc  = acc_next;
                    n_hcnt = 2'd0;
                    if (r_phase == PH_HEX1) begin
                        if (acc_next[15:10] == 6'b110110) begin
                            n_hs = acc_next[9:0];
                            if (last) begin
                                n_term = 1'b1;
                                n_terr = ERR_SURROGATE;
                            end else begin
                                n_phase = PH_PAIR_BS;
                            end
                        end else if (acc_next[15:10] == 6'b110111) begin
                            n_term = 1'b1;
                            n_terr = ERR_SURROGATE;
                        end else begin
                            emit = 1'b1;
                            cp   = {5'd0, acc_next};
                        end
                    end else begin
                        if (acc_next[15:10] != 6'b110111) begin
                            n_term = 1'b1;
                            n_terr = ERR_SURROGATE;
                        end else begin
                            emit = 1'b1;
                            cp   = {11'(r_hs + 10'd0) + 11'd64, acc_next[9:0]};
                        end
                    end
                    if (emit) begin
                        n_phase = PH_BODY;
                        if (last) begin
                            n_term = 1'b1;
                            n_terr = ERR_UNTERM;
                        end
                    end
                end
            end
            PH_PAIR_BS: begin
                if (c != "\\" || last) begin
                    n_term = 1'b1;
                    n_terr = ERR_SURROGATE;
                end else begin
                    n_phase = PH_PAIR_U;
                end
            end
            PH_PAIR_U: begin
                if (c != "u") begin
                    n_term = 1'b1;
                    n_terr = ERR_SURROGATE;
                end else if (last) begin
                    n_term = 1'b1;
                    n_terr = ERR_SHORT_HEX;
                end else begin
                    n_phase = PH_HEX2;
                    n_hcnt  = 2'd0;
                    n_acc   = '0;
                end
            end
            PH_FINISH: begin
            end
            default: begin
            end
        endcase
        if (n_term) begin
            n_phase = PH_FINISH;
        end
        enc      = utf8_enc(cp);
        n_bytes  = enc.bytes;
        n_nbytes = emit ? enc.count : 3'd0;
        if (raw) begin
            n_bytes  = {24'h000000, c};
            n_nbytes = 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_QUOTE;
            r_hcnt  <= '0;
            r_acc   <= '0;
            r_hs    <= '0;
            r_total <= '0;
            r_idx   <= '0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_hcnt  <= n_hcnt;
                r_acc   <= n_acc;
                r_hs    <= n_hs;
                r_total <= n_nbytes + {2'b00, n_term};
                r_idx   <= '0;
            end else if (out_xfer) begin
                if (o_m_tlast) begin
                    r_total <= '0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes  <= n_bytes;
            r_nbytes <= n_nbytes;
            r_tkind  <= n_tkind;
            r_terr   <= n_terr;
        end
    end

endmodule

>>> tb/sv/json_string_unescape_utf8_tb.sv
// Testbench for json_string_unescape_utf8: drives one JSON string token over
// the slave stream, predicts the decoded UTF-8 and status transfers and
// checks them on the master stream. Depends on jsu_pkg and the RTL top.
module json_string_unescape_utf8_tb
    import jsu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        t_err       err;
        logic       last;
    } t_decoded;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } t_text_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;   // [7:0] in_byte
    logic        i_s_tlast = 1'b0;    // end_of_text
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;           // [7:0] out_byte, [11:8] error_code, [15:12] zero
    logic [1:0]  o_m_tuser;           // [1:0] kind
    logic        o_m_tlast;           // last_of_run

    int          gap_pct = 0;
    int          stall_pct = 0;
    int          ignored_n = 0;
    t_text_byte  text_q[$];
    logic [7:0]  esc_chars [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

    // bit 4 set for a non-hex character
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") begin
            return {1'b0, b[3:0]};
        end
        if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            return {1'b0, b[3:0] + 4'd9};
        end
        return 5'h10;
    endfunction

    class unescape_scoreboard;
        t_phase      phase;
        logic [1:0]  hex_cnt;
        logic [15:0] accum;
        logic [9:0]  hi_sur;
        t_decoded    decoded_q[$];
        t_decoded    run_q[$];
        int          errors;
        int          checked;
        int          accepted;
        t_kind       end_kind;
        t_err        ending;

        function new();
            phase    = PH_QUOTE;
            hex_cnt  = 2'd0;
            accum    = 16'h0000;
            hi_sur   = 10'h000;
            errors   = 0;
            checked  = 0;
            accepted = 0;
            end_kind = KIND_DATA;
            ending   = ERR_NONE;
        endfunction

        function void add(t_kind kind, logic [7:0] value, t_err err);
            t_decoded d;
            d = '{kind: kind, value: value, err: err, last: 1'b0};
            run_q = {run_q, d};
        endfunction

        function void abort(t_err err);
            phase = PH_FINISH;
            add(KIND_ERROR, 8'h00, err);
        endfunction

        function void put_code_point(logic [20:0] cp);
            if (cp <= 21'h7f) begin
                add(KIND_DATA, cp[7:0], ERR_NONE);
            end else if (cp <= 21'h7ff) begin
                add(KIND_DATA, {3'b110, cp[10:6]}, ERR_NONE);
                add(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
            end else if (cp <= 21'hffff) begin
                add(KIND_DATA, {4'b1110, cp[15:12]}, ERR_NONE);
                add(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
                add(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
            end else begin
                add(KIND_DATA, {5'b11110, cp[20:18]}, ERR_NONE);
                add(KIND_DATA, {2'b10, cp[17:12]}, ERR_NONE);
                add(KIND_DATA, {2'b10, cp[11:6]}, ERR_NONE);
                add(KIND_DATA, {2'b10, cp[5:0]}, ERR_NONE);
            end
        endfunction

        function void decode_byte(logic [7:0] b, logic eot);
            logic [4:0]  nib;
            logic [7:0]  esc;
            logic        esc_ok;
            logic [20:0] cp;
            run_q = {};
            accepted++;
            case (phase)
                PH_QUOTE: begin
                    if (b != "\"") abort(ERR_NO_QUOTE);
                    else if (eot) abort(ERR_UNTERM);
                    else phase = PH_BODY;
                end
                PH_BODY: begin
                    if (b == "\"") begin
                        phase = PH_FINISH;
                        add(KIND_DONE, 8'h00, ERR_NONE);
                    end else if (b < 8'h20) begin
                        abort(ERR_CONTROL);
                    end else if (b == "\\") begin
                        if (eot) abort(ERR_SHORT_ESC);
                        else phase = PH_ESC;
                    end else begin
                        add(KIND_DATA, b, ERR_NONE);
                        if (eot) abort(ERR_UNTERM);
                    end
                end
                PH_ESC: begin
                    esc_ok = 1'b1;
                    esc = b;
                    case (b)
                        "\"", "\\", "/": esc = b;
                        "b": esc = 8'h08;
                        "f": esc = 8'h0c;
                        "n": esc = 8'h0a;
                        "r": esc = 8'h0d;
                        "t": esc = 8'h09;
                        default: esc_ok = 1'b0;
                    endcase
                    if (esc_ok) begin
                        phase = PH_BODY;
                        add(KIND_DATA, esc, ERR_NONE);
                        if (eot) abort(ERR_UNTERM);
                    end else if (b == "u") begin
                        if (eot) begin
                            abort(ERR_SHORT_HEX);
                        end else begin
                            phase = PH_HEX1;
                            hex_cnt = 2'd0;
                            accum = 16'h0000;
                        end
                    end else begin
                        abort(ERR_BAD_ESC);
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    nib = nibble_of(b);
                    if (nib[4]) begin
                        abort(ERR_BAD_HEX);
                    end else begin
                        accum = {accum[11:0], nib[3:0]};
                        if (hex_cnt != 2'd3) begin
                            hex_cnt = hex_cnt + 2'd1;
                            if (eot) abort(ERR_SHORT_HEX);
                        end else begin
                            hex_cnt = 2'd0;
                            if (phase == PH_HEX1 && accum[15:10] == 6'b110110) begin
                                hi_sur = accum[9:0];
                                if (eot) abort(ERR_SURROGATE);
                                else phase = PH_PAIR_BS;
                            end else if ((phase == PH_HEX1) == (accum[15:10] == 6'b110111)) begin
                                // low half alone, or second half not a low surrogate
                                abort(ERR_SURROGATE);
                            end else begin
                                if (phase == PH_HEX2) cp = {1'b0, hi_sur, accum[9:0]} + 21'h10000;
                                else cp = {5'b00000, accum};
                                phase = PH_BODY;
                                put_code_point(cp);
                                if (eot) abort(ERR_UNTERM);
                            end
                        end
                    end
                end
                PH_PAIR_BS: begin
                    if (b != "\\" || eot) abort(ERR_SURROGATE);
                    else phase = PH_PAIR_U;
                end
                PH_PAIR_U: begin
                    if (b != "u") begin
                        abort(ERR_SURROGATE);
                    end else if (eot) begin
                        abort(ERR_SHORT_HEX);
                    end else begin
                        phase = PH_HEX2;
                        hex_cnt = 2'd0;
                        accum = 16'h0000;
                    end
                end
                default: ;
            endcase
            if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
            foreach (run_q[i]) decoded_q = {decoded_q, run_q[i]};
        endfunction

        function void compare(string field, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_output(logic [15:0] data, logic [1:0] user, logic last);
            t_decoded d;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual kind %0h data %0h",
                         $time, user, data);
                errors++;
                return;
            end
            d = decoded_q.pop_front();
            compare("kind", d.kind, user);
            compare("out_byte", d.value, data[7:0]);
            compare("error_code", d.err, data[11:8]);
            compare("tdata pad", 0, data[15:12]);
            compare("last_of_run", d.last, last);
            checked++;
            if (d.kind != KIND_DATA) begin
                end_kind = d.kind;
                ending = d.err;
            end
        endfunction
    endclass

    unescape_scoreboard sb;

    json_string_unescape_utf8 i_dut (
        .i_clk,
        .i_rst_n,
        .i_s_tvalid,
        .o_s_tready,
        .i_s_tdata,
        .i_s_tlast,
        .o_m_tvalid,
        .i_m_tready,
        .o_m_tdata,
        .o_m_tuser,
        .o_m_tlast
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) sb.decode_byte(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) sb.check_output(o_m_tdata, o_m_tuser, o_m_tlast);
        end
    end

    function automatic void push(logic [7:0] b, logic eot);
        t_text_byte t;
        t = '{b: b, eot: eot};
        text_q = {text_q, t};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + nib;
        return ($urandom_range(1) ? "a" : "A") + nib - 8'd10;
    endfunction

    function automatic logic [7:0] rand_raw();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hff)); while (b == "\"" || b == "\\");
        return b;
    endfunction

    function automatic logic [15:0] rand_bmp();
        case ($urandom_range(2))
            0: return 16'($urandom_range(16'h0000, 16'h007f));
            1: return 16'($urandom_range(16'h0080, 16'h07ff));
            default: begin
                if ($urandom_range(1)) return 16'($urandom_range(16'h0800, 16'hd7ff));
                return 16'($urandom_range(16'he000, 16'hffff));
            end
        endcase
    endfunction

    function automatic void add_uescape(logic [15:0] code, logic eot);
        push("\\", 1'b0);
        push("u", 1'b0);
        for (int j = 3; j >= 0; j--) push(hex_char(code[j*4 +: 4]), eot && j == 0);
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'hd800 + 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] rand_low();
        return 16'hdc00 + 16'($urandom_range(0, 1023));
    endfunction

    // One string per run: the way it ends is picked by the seed.
    function automatic void build_text();
        int         sel;
        int         k;
        logic [7:0] b;
        logic [15:0] code;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            do b = 8'($urandom_range(0, 255)); while (b == "\"");
            push(b, 1'($urandom_range(1)));
        end else if (sel == 1) begin
            push("\"", 1'b1);
        end else begin
            push("\"", 1'b0);
            push(8'h20, 1'b0);
            push(8'h7f, 1'b0);
            push(8'h80, 1'b0);
            push(8'hff, 1'b0);
            foreach (esc_chars[j]) begin
                push("\\", 1'b0);
                push(esc_chars[j], 1'b0);
            end
            add_uescape(16'hffff, 1'b0);
            while (text_q.size() < 415) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push(rand_raw(), 1'b0);
                    4, 5: begin
                        push("\\", 1'b0);
                        push(esc_chars[$urandom_range(0, 7)], 1'b0);
                    end
                    6, 7: add_uescape(rand_bmp(), 1'b0);
                    default: begin
                        add_uescape(rand_high(), 1'b0);
                        add_uescape(rand_low(), 1'b0);
                    end
                endcase
            end
            case (sel - 2)
                0, 1, 2: push("\"", 1'($urandom_range(1)));
                3: push(8'($urandom_range(0, 31)), 1'($urandom_range(1)));
                4: push(rand_raw(), 1'b1);
                5: begin
                    push("\\", 1'b0);
                    push(esc_chars[$urandom_range(0, 7)], 1'b1);
                end
                6: add_uescape(rand_bmp(), 1'b1);
                7: begin
                    add_uescape(rand_high(), 1'b0);
                    add_uescape(rand_low(), 1'b1);
                end
                8: push("\\", 1'b1);
                9: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b inside {"\"", "\\", "/", "b", "f", "n", "r", "t", "u"});
                    push("\\", 1'b0);
                    push(b, 1'($urandom_range(1)));
                end
                10: begin
                    push("\\", 1'b0);
                    push("u", 1'b1);
                end
                11: begin
                    push("\\", 1'b0);
                    push("u", 1'b0);
                    k = $urandom_range(1, 3);
                    for (int j = 0; j < k; j++)
                        push(hex_char(4'($urandom_range(15))), j == k - 1);
                end
                12: begin
                    push("\\", 1'b0);
                    push("u", 1'b0);
                    k = $urandom_range(0, 3);
                    for (int j = 0; j < k; j++) push(hex_char(4'($urandom_range(15))), 1'b0);
                    do b = 8'($urandom_range(0, 255)); while (nibble_of(b) < 5'h10);
                    push(b, 1'($urandom_range(1)));
                end
                13: add_uescape(rand_high(), 1'b1);
                14: begin
                    add_uescape(rand_high(), 1'b0);
                    do b = 8'($urandom_range(0, 255)); while (b == "\\");
                    push(b, 1'($urandom_range(1)));
                end
                15: begin
                    add_uescape(rand_high(), 1'b0);
                    if ($urandom_range(1)) begin
                        push("\\", 1'b1);
                    end else begin
                        push("\\", 1'b0);
                        do b = 8'($urandom_range(0, 255)); while (b == "u");
                        push(b, 1'($urandom_range(1)));
                    end
                end
                16: begin
                    add_uescape(rand_high(), 1'b0);
                    if ($urandom_range(1)) begin
                        push("\\", 1'b0);
                        push("u", 1'b1);
                    end else begin
                        if ($urandom_range(1)) code = 16'($urandom_range(16'h0000, 16'hdbff));
                        else code = 16'($urandom_range(16'he000, 16'hffff));
                        add_uescape(code, 1'($urandom_range(1)));
                    end
                end
                default: add_uescape(rand_low(), 1'($urandom_range(1)));
            endcase
        end
        // the block drops everything after the end of the string
        if (text_q.size() < 420) ignored_n = 430 - text_q.size();
        else ignored_n = 10;
        for (int j = 0; j < ignored_n; j++)
            push(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
    endfunction

    task automatic drive_text();
        int n;
        int quarter;
        n = text_q.size();
        quarter = n / 4;
        for (int i = 0; i < n; i++) begin
            if (i < quarter) begin
                gap_pct = 0;
                stall_pct = 0;
            end else if (i < 2 * quarter) begin
                gap_pct = 71;
                stall_pct = 0;
            end else if (i < 3 * quarter) begin
                gap_pct = 0;
                stall_pct = 71;
            end else begin
                gap_pct = 38;
                stall_pct = 38;
            end
            while ($urandom_range(99) < gap_pct) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= text_q[i].b;
            i_s_tlast  <= text_q[i].eot;
            do @(posedge i_clk); while (!o_s_tready);
        end
        i_s_tvalid <= 1'b0;
    endtask

    initial begin
        sb = new();
        build_text();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_text();
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Sent %0d text bytes (%0d after the string end), checked %0d decoded transfers",
                 sb.accepted, ignored_n, sb.checked);
        $display("String closed with %s / %s", sb.end_kind.name(), sb.ending.name());
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
